/* src/cha_pkg.sv */
`timescale 1ns / 1ps

package cha_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int IDX_OUT_W       = 8;

  localparam logic FUNC_DEPOSIT   = 1'b0;
  localparam logic FUNC_END_EVENT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } cha_state_t;

  // Search token handed from cell to cell along the key chain.
  typedef struct packed {
    logic active;
    logic found;
  } cha_tok_t;

  typedef struct packed {
    logic [31:0] cell_key;
    logic [15:0] origin_id;
  } cha_key_t;

  typedef struct packed {
    logic [31:0]        energy;
    logic [23:0]        time_val;
    logic [15:0]        particle;
    logic signed [55:0] wx;
    logic signed [55:0] wy;
    logic signed [55:0] wz;
  } cha_entry_t;

  typedef struct packed {
    logic [23:0] track_num;
    logic [23:0] parent_track_num;
  } cha_trk_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] entry_index;
    logic                 created_new;
    logic                 table_full;
    logic [31:0]          total_energy;
    logic [23:0]          earliest_time;
    logic [15:0]          earliest_particle;
    logic signed [55:0]   weighted_x;
    logic signed [55:0]   weighted_y;
    logic signed [55:0]   weighted_z;
  } cha_res_t;

  function automatic logic [31:0] sat_add_energy(logic [31:0] a, logic [23:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {9'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic signed [55:0] sat_add_w(logic signed [55:0] a,
                                                   logic signed [55:0] b);
    logic [56:0] s;
    s = {a[55], a} + {b[55], b};
    if (s[56] != s[55]) begin
      return s[56] ? {1'b1, 55'b0} : {1'b0, {55{1'b1}}};
    end
    return s[55:0];
  endfunction

  // Unsigned energy times signed position, sign-extended to the sum width.
  function automatic logic signed [55:0] weight(logic [23:0] e, logic signed [23:0] p);
    logic signed [48:0] prod;
    prod = $signed({1'b0, e}) * p;
    return {{7{prod[48]}}, prod};
  endfunction

endpackage

/* src/cha_if.sv */
`timescale 1ns / 1ps

interface cha_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [31:0]        cell_key;
  logic [15:0]        origin_id;
  logic [23:0]        energy;
  logic [23:0]        arrival_time;
  logic signed [23:0] pos_x;
  logic signed [23:0] pos_y;
  logic signed [23:0] pos_z;
  logic [15:0]        particle_code;
  logic [23:0]        track_num;
  logic [23:0]        parent_track_num;

  modport source (
    output valid, func, cell_key, origin_id, energy, arrival_time,
           pos_x, pos_y, pos_z, particle_code, track_num, parent_track_num,
    input  ready
  );
  modport sink (
    input  valid, func, cell_key, origin_id, energy, arrival_time,
           pos_x, pos_y, pos_z, particle_code, track_num, parent_track_num,
    output ready
  );
endinterface

interface cha_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         entry_index;
  logic               created_new;
  logic               table_full;
  logic [31:0]        total_energy;
  logic [23:0]        earliest_time;
  logic [15:0]        earliest_particle;
  logic signed [55:0] weighted_x;
  logic signed [55:0] weighted_y;
  logic signed [55:0] weighted_z;

  modport source (
    output valid, entry_index, created_new, table_full, total_energy, earliest_time,
           earliest_particle, weighted_x, weighted_y, weighted_z,
    input  ready
  );
  modport sink (
    input  valid, entry_index, created_new, table_full, total_energy, earliest_time,
           earliest_particle, weighted_x, weighted_y, weighted_z,
    output ready
  );
endinterface

/* src/cha_cell.sv */
`timescale 1ns / 1ps

module cha_cell #(
  parameter int DEPTH = cha_pkg::TABLE_DEPTH_DEF,
  parameter int INDEX = 0,
  localparam int IW = $clog2(DEPTH),
  localparam int FW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cha_pkg::cha_tok_t tok_in,
  input  logic [IW-1:0]    idx_in,
  output cha_pkg::cha_tok_t tok_out,
  output logic [IW-1:0]    idx_out,
  input  cha_pkg::cha_key_t query,
  input  logic [FW-1:0]    fill_count,
  input  logic             key_wr_en
);

  cha_pkg::cha_key_t key_r;
  cha_pkg::cha_tok_t tok_r, tok_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              slot_live;
  logic              hit;

  // Slots are opened in order, so a slot holds a live key exactly when it
  // lies below the fill count.
  assign slot_live = FW'(INDEX) < fill_count;
  assign hit = tok_in.active && !tok_in.found && slot_live && (key_r == query);

  always_comb begin
    tok_nxt.active = tok_in.active;
    tok_nxt.found  = tok_in.found | hit;
    idx_nxt        = hit ? IW'(INDEX) : idx_in;
  end

  always_ff @(posedge clk) begin
    if (key_wr_en && (fill_count == FW'(INDEX))) begin
      key_r <= query;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
    idx_r <= idx_nxt;
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

/* src/cha_store.sv */
`timescale 1ns / 1ps

module cha_store #(
  parameter int DEPTH = cha_pkg::TABLE_DEPTH_DEF,
  localparam int IW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  cha_pkg::cha_entry_t wr_entry,
  input  cha_pkg::cha_trk_t   wr_trk,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output cha_pkg::cha_entry_t rd_entry
);

  cha_pkg::cha_entry_t entry_mem [DEPTH];
  cha_pkg::cha_trk_t   trk_mem [DEPTH];
  cha_pkg::cha_entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_entry;
      trk_mem[wr_addr]   <= wr_trk;
    end
    if (rd_en) begin
      rd_entry_r <= entry_mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

/* src/calorimeter_hit_accumulator.sv */
`timescale 1ns / 1ps

// Channel   Modport        Direction  Content
// in_ch     cha_in_if      sink       deposit or end-of-event command
// out_ch    cha_out_if     source     updated, opened or rejected table entry
//
// A deposit walks a token down a chain of TABLE_DEPTH key cells, one cell per
// cycle. A new entry or a full table loads the result register as the token leaves
// the chain; an update of an existing entry passes through the update state for the
// entry memory read first. The emit state moves the result to the output register.
// End-of-event and zero-energy transactions produce no result. One deposit is in
// flight at a time. Reset is synchronous and empties the table at once; a stalled
// result waits in the output register while the next transaction is accepted.

module calorimeter_hit_accumulator #(
  parameter int TABLE_DEPTH = cha_pkg::TABLE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  cha_in_if.sink    in_ch,
  cha_out_if.source out_ch
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int FW = $clog2(TABLE_DEPTH + 1);

  cha_pkg::cha_state_t state_r, state_nxt;

  logic                launch_r;
  logic [FW-1:0]       fill_r;
  cha_pkg::cha_key_t   q_key_r;
  logic [23:0]         q_energy_r;
  logic [23:0]         q_time_r;
  logic [15:0]         q_part_r;
  logic signed [23:0]  q_x_r, q_y_r, q_z_r;
  cha_pkg::cha_trk_t   q_trk_r;
  logic signed [55:0]  prod_x_r, prod_y_r, prod_z_r;
  logic [IW-1:0]       hit_idx_r;
  cha_pkg::cha_res_t   res_r, res_nxt;
  cha_pkg::cha_res_t   out_r;
  logic                out_valid_r;

  cha_pkg::cha_tok_t   tok [TABLE_DEPTH+1];
  logic [IW-1:0]       tok_idx [TABLE_DEPTH+1];
  cha_pkg::cha_tok_t   tok_end;
  logic [IW-1:0]       idx_end;

  logic                in_ready;
  logic                accept;
  logic                start;
  logic                clear;
  logic                scan_done;
  logic                is_full;
  logic                new_en;
  logic                upd_en;
  logic                rd_en;
  logic                wr_en;
  logic                load_res;
  logic                load_out;
  logic [IW-1:0]       wr_addr;
  cha_pkg::cha_entry_t wr_entry;
  cha_pkg::cha_entry_t new_entry;
  cha_pkg::cha_entry_t upd_entry;
  cha_pkg::cha_entry_t rd_entry;
  logic [IW+7:0]       new_idx_ext;
  logic [IW+7:0]       hit_idx_ext;

  // Key chain.
  assign tok[0]     = '{active: launch_r, found: 1'b0};
  assign tok_idx[0] = '0;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    cha_cell #(
      .DEPTH (TABLE_DEPTH),
      .INDEX (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_in     (tok[g]),
      .idx_in     (tok_idx[g]),
      .tok_out    (tok[g+1]),
      .idx_out    (tok_idx[g+1]),
      .query      (q_key_r),
      .fill_count (fill_r),
      .key_wr_en  (new_en)
    );
  end

  assign tok_end = tok[TABLE_DEPTH];
  assign idx_end = tok_idx[TABLE_DEPTH];

  cha_store #(
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .wr_trk   (q_trk_r),
    .rd_en    (rd_en),
    .rd_addr  (idx_end),
    .rd_entry (rd_entry)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cha_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = cha_pkg::ST_SCAN;
        end
      end
      cha_pkg::ST_SCAN: begin
        if (tok_end.active) begin
          state_nxt = tok_end.found ? cha_pkg::ST_UPDATE : cha_pkg::ST_EMIT;
        end
      end
      cha_pkg::ST_UPDATE: begin
        state_nxt = cha_pkg::ST_EMIT;
      end
      cha_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = cha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cha_pkg::ST_IDLE;
      end
    endcase
  end

  // Controls and datapath.
  always_comb begin
    in_ready  = (state_r == cha_pkg::ST_IDLE);
    accept    = in_ch.valid && in_ready;
    start     = accept && (in_ch.func == cha_pkg::FUNC_DEPOSIT) && (in_ch.energy != '0);
    clear     = accept && (in_ch.func == cha_pkg::FUNC_END_EVENT);
    scan_done = (state_r == cha_pkg::ST_SCAN) && tok_end.active;
    is_full   = (fill_r == FW'(TABLE_DEPTH));
    rd_en     = scan_done && tok_end.found;
    new_en    = scan_done && !tok_end.found && !is_full;
    upd_en    = (state_r == cha_pkg::ST_UPDATE);
    load_res  = (scan_done && !tok_end.found) || upd_en;
    load_out  = (state_r == cha_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);
    wr_en     = new_en || upd_en;
    wr_addr   = upd_en ? hit_idx_r : fill_r[IW-1:0];

    new_entry.energy   = {8'b0, q_energy_r};
    new_entry.time_val = q_time_r;
    new_entry.particle = q_part_r;
    new_entry.wx       = prod_x_r;
    new_entry.wy       = prod_y_r;
    new_entry.wz       = prod_z_r;

    upd_entry.energy = cha_pkg::sat_add_energy(rd_entry.energy, q_energy_r);
    upd_entry.wx     = cha_pkg::sat_add_w(rd_entry.wx, prod_x_r);
    upd_entry.wy     = cha_pkg::sat_add_w(rd_entry.wy, prod_y_r);
    upd_entry.wz     = cha_pkg::sat_add_w(rd_entry.wz, prod_z_r);
    // Only a strictly earlier time takes over the time and particle code.
    if (q_time_r < rd_entry.time_val) begin
      upd_entry.time_val = q_time_r;
      upd_entry.particle = q_part_r;
    end else begin
      upd_entry.time_val = rd_entry.time_val;
      upd_entry.particle = rd_entry.particle;
    end

    wr_entry = upd_en ? upd_entry : new_entry;

    new_idx_ext = {8'b0, fill_r[IW-1:0]};
    hit_idx_ext = {8'b0, hit_idx_r};

    res_nxt = '0;
    if (upd_en) begin
      res_nxt.entry_index       = hit_idx_ext[7:0];
      res_nxt.total_energy      = upd_entry.energy;
      res_nxt.earliest_time     = upd_entry.time_val;
      res_nxt.earliest_particle = upd_entry.particle;
      res_nxt.weighted_x        = upd_entry.wx;
      res_nxt.weighted_y        = upd_entry.wy;
      res_nxt.weighted_z        = upd_entry.wz;
    end else if (is_full) begin
      res_nxt.table_full = 1'b1;
    end else begin
      res_nxt.entry_index       = new_idx_ext[7:0];
      res_nxt.created_new       = 1'b1;
      res_nxt.total_energy      = new_entry.energy;
      res_nxt.earliest_time     = new_entry.time_val;
      res_nxt.earliest_particle = new_entry.particle;
      res_nxt.weighted_x        = new_entry.wx;
      res_nxt.weighted_y        = new_entry.wy;
      res_nxt.weighted_z        = new_entry.wz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cha_pkg::ST_IDLE;
      launch_r    <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= start;
      if (clear) begin
        fill_r <= '0;
      end else if (new_en) begin
        fill_r <= fill_r + FW'(1);
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_key_r    <= '{cell_key: in_ch.cell_key, origin_id: in_ch.origin_id};
      q_energy_r <= in_ch.energy;
      q_time_r   <= in_ch.arrival_time;
      q_part_r   <= in_ch.particle_code;
      q_x_r      <= in_ch.pos_x;
      q_y_r      <= in_ch.pos_y;
      q_z_r      <= in_ch.pos_z;
      q_trk_r    <= '{track_num: in_ch.track_num, parent_track_num: in_ch.parent_track_num};
    end
    // The products settle long before the scan finishes.
    prod_x_r <= cha_pkg::weight(q_energy_r, q_x_r);
    prod_y_r <= cha_pkg::weight(q_energy_r, q_y_r);
    prod_z_r <= cha_pkg::weight(q_energy_r, q_z_r);
    if (scan_done) begin
      hit_idx_r <= idx_end;
    end
    if (load_res) begin
      res_r <= res_nxt;
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.entry_index       = out_r.entry_index;
  assign out_ch.created_new       = out_r.created_new;
  assign out_ch.table_full        = out_r.table_full;
  assign out_ch.total_energy      = out_r.total_energy;
  assign out_ch.earliest_time     = out_r.earliest_time;
  assign out_ch.earliest_particle = out_r.earliest_particle;
  assign out_ch.weighted_x        = out_r.weighted_x;
  assign out_ch.weighted_y        = out_r.weighted_y;
  assign out_ch.weighted_z        = out_r.weighted_z;

endmodule
